[src/vcos_pkg.sv]
// Shared constants, types and helpers of the voxel column occlusion core.
package vcos_pkg;

    // Size of the column mark store and the widest step
    localparam int MAX_COLUMNS = 1024;
    localparam int MAX_STEP    = 8;

    // Field widths
    localparam int COLUMN_W   = 10;
    localparam int DEPTH_W    = 16;
    localparam int TERRAIN_W  = 8;
    localparam int COLOR_W    = 8;
    localparam int STEP_W     = 4;
    localparam int TOP_W      = 11;
    localparam int SPAN_TOP_W = 10;
    localparam int CAMERA_W   = 24;
    localparam int SCALE_W    = 16;
    localparam int HORIZON_W  = 12;

    // Input item kinds
    localparam logic KIND_FRAME  = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;
    localparam logic [CFG_INDEX_W-1:0] CFG_CAMERA_HEIGHT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT_SCALE  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HORIZON_ROW   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_ROWS   = 2'd3;

    localparam logic [CAMERA_W-1:0]  CAMERA_RESET  = 24'd5120;
    localparam logic [SCALE_W-1:0]   SCALE_RESET   = 16'd30720;
    localparam logic [HORIZON_W-1:0] HORIZON_RESET = 12'd100;
    localparam logic [TOP_W-1:0]     SCREEN_RESET  = 11'd200;

    // Mark store: one RAM lane per column modulo LANES, one row per LANES columns
    localparam int LANE_BITS = (MAX_STEP > 2) ? $clog2(MAX_STEP) : 1;
    localparam int LANES     = 1 << LANE_BITS;
    localparam int ROWS      = (MAX_COLUMNS + LANES - 1) / LANES;
    localparam int ROW_W     = (ROWS > 2) ? $clog2(ROWS) : 1;
    localparam int ROOM_W    = (($clog2(MAX_COLUMNS + 1) > COLUMN_W) ?
                                $clog2(MAX_COLUMNS + 1) : COLUMN_W) + 1;
    localparam int CMP_W     = STEP_W + 1;

    // Projection arithmetic
    localparam int TERRAIN_SHIFT = 8;
    localparam int FRAC_SHIFT    = 12;
    localparam int DIFF_W        = CAMERA_W + 1;
    localparam int PROD_W        = DIFF_W + SCALE_W + 1;
    localparam int QIN_W         = PROD_W - FRAC_SHIFT;
    localparam int MAG_W         = QIN_W - 1;
    localparam int QUOT_W        = 12;
    localparam int REM_W         = DEPTH_W + QUOT_W;
    localparam int ROW_SUM_W     = QUOT_W + 2;

    typedef struct packed {
        logic                frame;
        logic                sample;
        logic [COLUMN_W-1:0] column;
        logic [STEP_W-1:0]   width;
        logic [COLOR_W-1:0]  color;
    } item_t;

    typedef struct packed {
        logic busy;
        logic clearing;
    } occl_status_t;

    function automatic logic [ROW_W-1:0] col_row(input logic [COLUMN_W-1:0] c);
        logic [ROOM_W-1:0] e;
        e = ROOM_W'(c) >> LANE_BITS;
        return e[ROW_W-1:0];
    endfunction

endpackage

[src/vcos_ram.sv]
// Generic single write port RAM with registered read.
module vcos_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/vcos_front.sv]
// Front stages: step clipping, height difference times scale, magnitude and range check.
module vcos_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           adv,
    input  logic                           in_fire,
    input  logic                           kind,
    input  logic [vcos_pkg::COLUMN_W-1:0]  column,
    input  logic [vcos_pkg::DEPTH_W-1:0]   depth,
    input  logic [vcos_pkg::TERRAIN_W-1:0] terrain_height,
    input  logic [vcos_pkg::COLOR_W-1:0]   texel_color,
    input  logic [vcos_pkg::STEP_W-1:0]    step_width,
    input  logic [vcos_pkg::CAMERA_W-1:0]  camera_height,
    input  logic [vcos_pkg::SCALE_W-1:0]   height_scale,
    output logic                           out_v,
    output vcos_pkg::item_t                out_item,
    output logic                           out_neg,
    output logic                           out_big,
    output logic [vcos_pkg::REM_W-1:0]     out_rem,
    output logic [vcos_pkg::DEPTH_W-1:0]   out_den
);

    import vcos_pkg::*;

    logic [STEP_W-1:0]         step_c;
    logic [ROOM_W-1:0]         col_ext;
    logic [ROOM_W-1:0]         room;
    logic                      in_range;
    logic [STEP_W-1:0]         width_c;
    item_t                     item_c;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [PROD_W-1:0]  prod;
    logic [DEPTH_W-1:0]        den_c;

    logic                      v1_reg;
    item_t                     item1_reg;
    logic signed [PROD_W-1:0]  prod1_reg;
    logic [DEPTH_W-1:0]        den1_reg;

    logic signed [QIN_W-1:0]   qin;
    logic [QIN_W-1:0]          abs_full;
    logic                      v2_reg;
    item_t                     item2_reg;
    logic                      neg2_reg;
    logic [MAG_W-1:0]          mag2_reg;
    logic [DEPTH_W-1:0]        den2_reg;

    logic                      big_c;
    logic                      v3_reg;
    item_t                     item3_reg;
    logic                      neg3_reg;
    logic                      big3_reg;
    logic [REM_W-1:0]          rem3_reg;
    logic [DEPTH_W-1:0]        den3_reg;

    always_comb
    begin
        step_c = step_width;
        if (step_width == '0)
        begin
            step_c = STEP_W'(1);
        end
        else if (int'(step_width) > MAX_STEP)
        begin
            step_c = STEP_W'(MAX_STEP);
        end
        col_ext  = ROOM_W'(column);
        room     = ROOM_W'(MAX_COLUMNS) - col_ext;
        in_range = col_ext < ROOM_W'(MAX_COLUMNS);
        // clip the span at the right screen edge
        width_c  = (ROOM_W'(step_c) < room) ? step_c : room[STEP_W-1:0];

        item_c.frame  = (kind == KIND_FRAME);
        item_c.sample = (kind == KIND_SAMPLE) && in_range;
        item_c.column = column;
        item_c.width  = width_c;
        item_c.color  = texel_color;

        diff  = $signed({1'b0, camera_height})
              - $signed({{(DIFF_W - TERRAIN_W - TERRAIN_SHIFT){1'b0}}, terrain_height,
                         {TERRAIN_SHIFT{1'b0}}});
        prod  = diff * $signed({1'b0, height_scale});
        den_c = (depth == '0) ? DEPTH_W'(1) : depth;
    end

    always_comb
    begin
        qin      = prod1_reg[PROD_W-1:FRAC_SHIFT];
        abs_full = qin[QIN_W-1] ? QIN_W'(-qin) : QIN_W'(qin);
        big_c    = mag2_reg >= MAG_W'({den2_reg, {QUOT_W{1'b0}}});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_fire;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item1_reg <= item_c;
            prod1_reg <= prod;
            den1_reg  <= den_c;

            item2_reg <= item1_reg;
            neg2_reg  <= qin[QIN_W-1];
            mag2_reg  <= abs_full[MAG_W-1:0];
            den2_reg  <= den1_reg;

            item3_reg <= item2_reg;
            neg3_reg  <= neg2_reg;
            big3_reg  <= big_c;
            rem3_reg  <= mag2_reg[REM_W-1:0];
            den3_reg  <= den2_reg;
        end
    end

    assign out_v    = v3_reg;
    assign out_item = item3_reg;
    assign out_neg  = neg3_reg;
    assign out_big  = big3_reg;
    assign out_rem  = rem3_reg;
    assign out_den  = den3_reg;

endmodule

[src/vcos_div.sv]
// Pipelined restoring divider: one quotient bit per stage.
module vcos_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  logic                         in_v,
    input  vcos_pkg::item_t              in_item,
    input  logic                         in_neg,
    input  logic                         in_big,
    input  logic [vcos_pkg::REM_W-1:0]   in_rem,
    input  logic [vcos_pkg::DEPTH_W-1:0] in_den,
    output logic                         out_v,
    output vcos_pkg::item_t              out_item,
    output logic                         out_neg,
    output logic                         out_big,
    output logic [vcos_pkg::QUOT_W-1:0]  out_quot,
    output logic [vcos_pkg::REM_W-1:0]   out_rem
);

    import vcos_pkg::*;

    logic               v_reg    [QUOT_W];
    item_t              item_reg [QUOT_W];
    logic               neg_reg  [QUOT_W];
    logic               big_reg  [QUOT_W];
    logic [REM_W-1:0]   rem_reg  [QUOT_W];
    logic [DEPTH_W-1:0] den_reg  [QUOT_W];
    logic [QUOT_W-1:0]  quot_reg [QUOT_W];

    for (genvar s = 0; s < QUOT_W; s++)
    begin : g_step
        localparam int STEP_BIT = QUOT_W - 1 - s;

        logic               v_in;
        item_t              item_in;
        logic               neg_in;
        logic               big_in;
        logic [REM_W-1:0]   rem_in;
        logic [DEPTH_W-1:0] den_in;
        logic [QUOT_W-1:0]  quot_in;
        logic [REM_W-1:0]   trial;
        logic               take;

        if (s == 0)
        begin : g_first
            assign v_in    = in_v;
            assign item_in = in_item;
            assign neg_in  = in_neg;
            assign big_in  = in_big;
            assign rem_in  = in_rem;
            assign den_in  = in_den;
            assign quot_in = '0;
        end
        else
        begin : g_next
            assign v_in    = v_reg[s-1];
            assign item_in = item_reg[s-1];
            assign neg_in  = neg_reg[s-1];
            assign big_in  = big_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign den_in  = den_reg[s-1];
            assign quot_in = quot_reg[s-1];
        end

        assign trial = REM_W'(den_in) << STEP_BIT;
        assign take  = rem_in >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                item_reg[s] <= item_in;
                neg_reg[s]  <= neg_in;
                big_reg[s]  <= big_in;
                den_reg[s]  <= den_in;
                rem_reg[s]  <= take ? (rem_in - trial) : rem_in;
                quot_reg[s] <= quot_in | (take ? (QUOT_W'(1) << STEP_BIT) : '0);
            end
        end
    end

    assign out_v    = v_reg[QUOT_W-1];
    assign out_item = item_reg[QUOT_W-1];
    assign out_neg  = neg_reg[QUOT_W-1];
    assign out_big  = big_reg[QUOT_W-1];
    assign out_quot = quot_reg[QUOT_W-1];
    assign out_rem  = rem_reg[QUOT_W-1];

endmodule

[src/vcos_occl.sv]
// Row finish, column mark lookup with bypass, span decision, mark update and clearing.
module vcos_occl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            adv,
    input  logic                            frame_fire,
    input  logic                            in_v,
    input  vcos_pkg::item_t                 in_item,
    input  logic                            in_neg,
    input  logic                            in_big,
    input  logic [vcos_pkg::QUOT_W-1:0]     in_quot,
    input  logic [vcos_pkg::REM_W-1:0]      in_rem,
    input  logic signed [vcos_pkg::HORIZON_W-1:0] horizon_row,
    input  logic [vcos_pkg::TOP_W-1:0]      screen_rows,
    output vcos_pkg::occl_status_t          status,
    output logic                            span_valid,
    output logic [vcos_pkg::COLUMN_W-1:0]   span_column,
    output logic [vcos_pkg::STEP_W-1:0]     span_width,
    output logic [vcos_pkg::SPAN_TOP_W-1:0] span_top,
    output logic [vcos_pkg::TOP_W-1:0]      span_rows,
    output logic [vcos_pkg::COLOR_W-1:0]    span_color
);

    import vcos_pkg::*;

    // row stage
    logic [ROW_SUM_W-1:0]        q_ext;
    logic signed [ROW_SUM_W-1:0] q_sgn;
    logic signed [ROW_SUM_W-1:0] row_sum;
    logic [TOP_W-1:0]            row_next;
    logic                        far_next;
    logic                        vr_reg;
    item_t                       itemr_reg;
    logic                        farr_reg;
    logic [TOP_W-1:0]            rowr_reg;
    logic [ROW_W-1:0]            rd_addr;

    // compare stage
    logic                        vc_reg;
    item_t                       itemc_reg;
    logic                        farc_reg;
    logic [TOP_W-1:0]            rowc_reg;
    logic                        byp_hit_reg;
    logic [TOP_W-1:0]            byp_row_reg;
    logic [TOP_W-1:0]            lane_q [LANES];
    logic [LANE_BITS-1:0]        lane_c;
    logic [ROW_W-1:0]            row0_c;
    logic [TOP_W-1:0]            top;
    logic                        hit;
    logic                        wr;
    logic [ROOM_W-1:0]           col_off;
    logic                        covers;

    // clearing pass
    logic                        clear_busy_reg;
    logic                        hold_reg;
    logic [ROW_W-1:0]            clr_addr_reg;
    logic [TOP_W-1:0]            fill_reg;

    // output register
    logic                        span_valid_reg;
    logic [COLUMN_W-1:0]         span_column_reg;
    logic [STEP_W-1:0]           span_width_reg;
    logic [SPAN_TOP_W-1:0]       span_top_reg;
    logic [TOP_W-1:0]            span_rows_reg;
    logic [COLOR_W-1:0]          span_color_reg;

    // floor division of a negative dividend rounds the magnitude up
    always_comb
    begin
        q_ext    = ROW_SUM_W'(in_quot) + ROW_SUM_W'(in_neg && (in_rem != '0));
        q_sgn    = in_neg ? -$signed(q_ext) : $signed(q_ext);
        row_sum  = q_sgn + ROW_SUM_W'(horizon_row);
        row_next = '0;
        far_next = 1'b0;
        if (in_big)
        begin
            far_next = !in_neg;
        end
        else if (!row_sum[ROW_SUM_W-1])
        begin
            // rows past the widest mark can never be above it
            far_next = |row_sum[ROW_SUM_W-2:TOP_W];
            row_next = row_sum[TOP_W-1:0];
        end
    end

    assign rd_addr = col_row(itemr_reg.column);

    always_comb
    begin
        lane_c  = itemc_reg.column[LANE_BITS-1:0];
        row0_c  = col_row(itemc_reg.column);
        top     = byp_hit_reg ? byp_row_reg : lane_q[lane_c];
        hit     = vc_reg && itemc_reg.sample && !farc_reg && (rowc_reg < top);
        wr      = hit && adv;
        col_off = ROOM_W'(itemr_reg.column) - ROOM_W'(itemc_reg.column);
        // the read issued this edge misses the write landing on the same edge
        covers  = hit && vr_reg && itemr_reg.sample
               && (itemr_reg.column >= itemc_reg.column)
               && (col_off < ROOM_W'(itemc_reg.width));
    end

    for (genvar j = 0; j < LANES; j++)
    begin : g_lane
        logic [LANE_BITS-1:0] ofs;
        logic                 cov;
        logic                 we;
        logic [ROW_W-1:0]     waddr;
        logic [TOP_W-1:0]     wdata;

        assign ofs   = LANE_BITS'(j) - lane_c;
        assign cov   = CMP_W'(ofs) < CMP_W'(itemc_reg.width);
        assign we    = clear_busy_reg || (wr && cov);
        assign waddr = clear_busy_reg ? clr_addr_reg
                     : (row0_c + ROW_W'(LANE_BITS'(j) < lane_c));
        assign wdata = clear_busy_reg ? fill_reg : rowc_reg;

        vcos_ram #(
            .WIDTH (TOP_W),
            .DEPTH (ROWS)
        ) u_ram (
            .clk   (clk),
            .we    (we),
            .waddr (waddr),
            .wdata (wdata),
            .re    (adv),
            .raddr (rd_addr),
            .rdata (lane_q[j])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vr_reg         <= 1'b0;
            vc_reg         <= 1'b0;
            span_valid_reg <= 1'b0;
            clear_busy_reg <= 1'b1;
            hold_reg       <= 1'b0;
            clr_addr_reg   <= '0;
            fill_reg       <= SCREEN_RESET;
        end
        else
        begin
            if (adv)
            begin
                vr_reg         <= in_v;
                vc_reg         <= vr_reg;
                span_valid_reg <= hit;
            end
            if (frame_fire)
            begin
                hold_reg <= 1'b1;
            end
            if (clear_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + ROW_W'(1);
                if (clr_addr_reg == ROW_W'(ROWS - 1))
                begin
                    clear_busy_reg <= 1'b0;
                    hold_reg       <= 1'b0;
                end
            end
            else if (adv && vc_reg && itemc_reg.frame)
            begin
                // frame start leaves the pipe: sweep every row with the new height
                clear_busy_reg <= 1'b1;
                clr_addr_reg   <= '0;
                fill_reg       <= screen_rows;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            itemr_reg   <= in_item;
            farr_reg    <= far_next;
            rowr_reg    <= row_next;
            itemc_reg   <= itemr_reg;
            farc_reg    <= farr_reg;
            rowc_reg    <= rowr_reg;
            byp_hit_reg <= covers;
            byp_row_reg <= rowc_reg;
            if (hit)
            begin
                span_column_reg <= itemc_reg.column;
                span_width_reg  <= itemc_reg.width;
                span_top_reg    <= rowc_reg[SPAN_TOP_W-1:0];
                span_rows_reg   <= top - rowc_reg;
                span_color_reg  <= itemc_reg.color;
            end
        end
    end

    assign status.busy     = hold_reg || clear_busy_reg;
    assign status.clearing = clear_busy_reg;
    assign span_valid      = span_valid_reg;
    assign span_column     = span_column_reg;
    assign span_width      = span_width_reg;
    assign span_top        = span_top_reg;
    assign span_rows       = span_rows_reg;
    assign span_color      = span_color_reg;

endmodule

[src/voxel_column_occlusion_spans_core.sv]
// Top level of the voxel column occlusion core: configuration registers and pipeline.
//
// Takes one terrain sample per cycle when neither stalled nor busy and returns at
// most one fill span per sample after three front stages (scale multiply,
// magnitude, range check), twelve divider stages at one quotient bit each, a row
// stage, a mark lookup stage and the output register. Column marks live in
// MAX_STEP-wide lanes of RAM (rounded up to a power of two), one column per lane,
// so all the columns of a span are written in the same cycle. A frame start drains
// the pipe and then sweeps the mark RAM one row of lanes per cycle, all 128 rows at
// the default size; the same sweep runs after reset. Samples are held off during
// the sweep while configuration writes are taken at any time.
module voxel_column_occlusion_spans_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sample_valid,
    output logic                              sample_stall,
    input  logic                              kind,
    input  logic [vcos_pkg::COLUMN_W-1:0]     column,
    input  logic [vcos_pkg::DEPTH_W-1:0]      depth,
    input  logic [vcos_pkg::TERRAIN_W-1:0]    terrain_height,
    input  logic [vcos_pkg::COLOR_W-1:0]      texel_color,
    input  logic [vcos_pkg::STEP_W-1:0]       step_width,
    output logic                              span_valid,
    input  logic                              span_stall,
    output logic [vcos_pkg::COLUMN_W-1:0]     span_column,
    output logic [vcos_pkg::STEP_W-1:0]       span_width,
    output logic [vcos_pkg::SPAN_TOP_W-1:0]   span_top,
    output logic [vcos_pkg::TOP_W-1:0]        span_rows,
    output logic [vcos_pkg::COLOR_W-1:0]      span_color,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [vcos_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [vcos_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import vcos_pkg::*;

    logic [CAMERA_W-1:0]         camera_height_reg;
    logic [SCALE_W-1:0]          height_scale_reg;
    logic signed [HORIZON_W-1:0] horizon_row_reg;
    logic [TOP_W-1:0]            screen_rows_reg;

    logic          adv;
    logic          in_fire;
    occl_status_t  status;

    logic               f_v;
    item_t              f_item;
    logic               f_neg;
    logic               f_big;
    logic [REM_W-1:0]   f_rem;
    logic [DEPTH_W-1:0] f_den;

    logic               d_v;
    item_t              d_item;
    logic               d_neg;
    logic               d_big;
    logic [QUOT_W-1:0]  d_quot;
    logic [REM_W-1:0]   d_rem;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            camera_height_reg <= CAMERA_RESET;
            height_scale_reg  <= SCALE_RESET;
            horizon_row_reg   <= HORIZON_RESET;
            screen_rows_reg   <= SCREEN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CAMERA_HEIGHT: camera_height_reg <= cfg_data[CAMERA_W-1:0];
                CFG_HEIGHT_SCALE:  height_scale_reg  <= cfg_data[SCALE_W-1:0];
                CFG_HORIZON_ROW:   horizon_row_reg   <= cfg_data[HORIZON_W-1:0];
                CFG_SCREEN_ROWS:   screen_rows_reg   <= cfg_data[TOP_W-1:0];
                default:           ;
            endcase
        end
    end

    // whole pipe moves when the output register is free or being taken
    assign adv          = !span_valid || !span_stall;
    assign sample_stall = !adv || status.busy;
    assign in_fire      = sample_valid && !sample_stall;

    vcos_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .adv            (adv),
        .in_fire        (in_fire),
        .kind           (kind),
        .column         (column),
        .depth          (depth),
        .terrain_height (terrain_height),
        .texel_color    (texel_color),
        .step_width     (step_width),
        .camera_height  (camera_height_reg),
        .height_scale   (height_scale_reg),
        .out_v          (f_v),
        .out_item       (f_item),
        .out_neg        (f_neg),
        .out_big        (f_big),
        .out_rem        (f_rem),
        .out_den        (f_den)
    );

    vcos_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_v     (f_v),
        .in_item  (f_item),
        .in_neg   (f_neg),
        .in_big   (f_big),
        .in_rem   (f_rem),
        .in_den   (f_den),
        .out_v    (d_v),
        .out_item (d_item),
        .out_neg  (d_neg),
        .out_big  (d_big),
        .out_quot (d_quot),
        .out_rem  (d_rem)
    );

    vcos_occl u_occl (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .frame_fire  (in_fire && (kind == KIND_FRAME)),
        .in_v        (d_v),
        .in_item     (d_item),
        .in_neg      (d_neg),
        .in_big      (d_big),
        .in_quot     (d_quot),
        .in_rem      (d_rem),
        .horizon_row (horizon_row_reg),
        .screen_rows (screen_rows_reg),
        .status      (status),
        .span_valid  (span_valid),
        .span_column (span_column),
        .span_width  (span_width),
        .span_top    (span_top),
        .span_rows   (span_rows),
        .span_color  (span_color)
    );

    a_frame_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && !sample_stall && (kind == KIND_FRAME)) |=> sample_stall)
        else $error("sample taken right after a frame start");

    a_sweep_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        status.clearing |-> sample_stall)
        else $error("sample taken during mark sweep");

    a_span_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        span_valid |-> ((span_rows != '0) && (span_width != '0)))
        else $error("empty span emitted");

endmodule

[dv/tb_voxel_column_occlusion_spans_core.sv]
// Self-checking testbench of the voxel column occlusion span core.
`timescale 1ns / 1ps

module tb_voxel_column_occlusion_spans_core;
    import vcos_pkg::*;

    localparam int CYCLE_LIMIT     = 500000;
    localparam int SETTLE_CYCLES   = 250;
    localparam int PRESSURE_CYCLES = 400;
    localparam int PHASE_ITEMS     = 155;

    typedef struct {
        bit                 kind;
        bit [COLUMN_W-1:0]  column;
        bit [DEPTH_W-1:0]   depth;
        bit [TERRAIN_W-1:0] terrain;
        bit [COLOR_W-1:0]   color;
        bit [STEP_W-1:0]    step;
    } sample_t;

    typedef struct {
        bit [COLUMN_W-1:0]   column;
        bit [STEP_W-1:0]     width;
        bit [SPAN_TOP_W-1:0] top;
        bit [TOP_W-1:0]      rows;
        bit [COLOR_W-1:0]    color;
    } span_t;

    class span_scoreboard;
        bit [CAMERA_W-1:0]         camera;
        bit [SCALE_W-1:0]          scale;
        bit signed [HORIZON_W-1:0] horizon;
        bit [TOP_W-1:0]            screen;
        bit [TOP_W-1:0]            marks [MAX_COLUMNS];
        span_t                     spans_due [$];
        int                        errors;

        function new();
            camera  = CAMERA_RESET;
            scale   = SCALE_RESET;
            horizon = HORIZON_RESET;
            screen  = SCREEN_RESET;
            errors  = 0;
            foreach (marks[c])
                marks[c] = screen;
        endfunction

        function void set_reg(bit [CFG_INDEX_W-1:0] index, bit [CFG_DATA_W-1:0] data);
            case (index)
                CFG_CAMERA_HEIGHT: camera  = data[CAMERA_W-1:0];
                CFG_HEIGHT_SCALE:  scale   = data[SCALE_W-1:0];
                CFG_HORIZON_ROW:   horizon = data[HORIZON_W-1:0];
                CFG_SCREEN_ROWS:   screen  = data[TOP_W-1:0];
                default: ;
            endcase
        endfunction

        // Exact quotient of the projection, truncated, negatives clamped to row 0
        function longint screen_row(bit [DEPTH_W-1:0] d, bit [TERRAIN_W-1:0] t);
            longint diff;
            longint den;
            longint num;
            diff = longint'(camera) - longint'(t) * 256;
            den  = (d == 0) ? 64'sd4096 : longint'(d) * 4096;
            num  = diff * longint'(scale) + longint'(horizon) * den;
            return (num < 0) ? 0 : num / den;
        endfunction

        function void note_sample(sample_t s);
            longint row;
            int     col;
            int     step;
            int     width;
            span_t  sp;
            if (s.kind == KIND_FRAME)
            begin
                foreach (marks[c])
                    marks[c] = screen;
                return;
            end
            col = s.column;
            if (col >= MAX_COLUMNS)
                return;
            step = s.step;
            if (step == 0)
                step = 1;
            if (step > MAX_STEP)
                step = MAX_STEP;
            width = (step > MAX_COLUMNS - col) ? MAX_COLUMNS - col : step;
            row = screen_row(s.depth, s.terrain);
            if (row >= marks[col])
                return;
            sp.column = COLUMN_W'(col);
            sp.width  = STEP_W'(width);
            sp.top    = row[SPAN_TOP_W-1:0];
            sp.rows   = marks[col] - row[TOP_W-1:0];
            sp.color  = s.color;
            spans_due.push_back(sp);
            for (int k = 0; k < width; k++)
                marks[col + k] = row[TOP_W-1:0];
        endfunction

        function void report(string field, int want, int got);
            if (want != got)
            begin
                $display("%0t: span %s expected %0d actual %0d", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_span(span_t got);
            span_t want;
            if (spans_due.size() == 0)
            begin
                $display("%0t: span with none expected: column %0d top %0d rows %0d",
                         $time, got.column, got.top, got.rows);
                errors++;
                return;
            end
            want = spans_due.pop_front();
            report("column", want.column, got.column);
            report("width", want.width, got.width);
            report("top", want.top, got.top);
            report("rows", want.rows, got.rows);
            report("color", want.color, got.color);
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   sample_valid;
    logic                   sample_stall;
    logic                   kind;
    logic [COLUMN_W-1:0]    column;
    logic [DEPTH_W-1:0]     depth;
    logic [TERRAIN_W-1:0]   terrain_height;
    logic [COLOR_W-1:0]     texel_color;
    logic [STEP_W-1:0]      step_width;
    logic                   span_valid;
    logic                   span_stall;
    logic [COLUMN_W-1:0]    span_column;
    logic [STEP_W-1:0]      span_width;
    logic [SPAN_TOP_W-1:0]  span_top;
    logic [TOP_W-1:0]       span_rows;
    logic [COLOR_W-1:0]     span_color;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    bit             calm = 1'b0;
    logic           hold_req = 1'b0;
    int             cycles = 0;
    span_scoreboard sb;

    voxel_column_occlusion_spans_core u_dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Span sink: check every transfer, stall at random or hold off once on request
    initial
    begin : span_sink
        int    hold_left;
        bit    hold_taken;
        span_t got;
        hold_left  = 0;
        hold_taken = 1'b0;
        span_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && span_valid && !span_stall)
            begin
                got.column = span_column;
                got.width  = span_width;
                got.top    = span_top;
                got.rows   = span_rows;
                got.color  = span_color;
                sb.check_span(got);
            end
            if (hold_req && !hold_taken)
            begin
                hold_left  = PRESSURE_CYCLES;
                hold_taken = 1'b1;
            end
            if (hold_left > 0)
            begin
                span_stall <= 1'b1;
                hold_left--;
            end
            else
                span_stall <= !calm && ($urandom_range(0, 99) < 15);
        end
    end

    // Idle a random gap, then offer the sample and hold it until the transfer
    task automatic send_sample(input sample_t s);
        int gap;
        gap = 0;
        if (!calm)
            while ($urandom_range(0, 99) < 15)
                gap++;
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid   <= 1'b1;
        kind           <= s.kind;
        column         <= s.column;
        depth          <= s.depth;
        terrain_height <= s.terrain;
        texel_color    <= s.color;
        step_width     <= s.step;
        do
            @(posedge clk);
        while (sample_stall);
        sb.note_sample(s);
    endtask

    task automatic send_fields(input bit k, input int col, input int d, input int t,
                               input int c, input int st);
        sample_t s;
        s.kind    = k;
        s.column  = COLUMN_W'(col);
        s.depth   = DEPTH_W'(d);
        s.terrain = TERRAIN_W'(t);
        s.color   = COLOR_W'(c);
        s.step    = STEP_W'(st);
        send_sample(s);
    endtask

    task automatic write_reg(input bit [CFG_INDEX_W-1:0] idx, input bit [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_reg(idx, data);
    endtask

    task automatic write_regs(input int cam, input int scl, input int hor, input int scr);
        write_reg(CFG_CAMERA_HEIGHT, CFG_DATA_W'(cam));
        write_reg(CFG_HEIGHT_SCALE, CFG_DATA_W'(scl));
        write_reg(CFG_HORIZON_ROW, CFG_DATA_W'(hor & 12'hFFF));
        write_reg(CFG_SCREEN_ROWS, CFG_DATA_W'(scr));
        cfg_valid <= 1'b0;
    endtask

    // Drop valid, wait for every expected span, then let the pipe and mark sweep finish
    task automatic settle();
        sample_valid <= 1'b0;
        while (sb.spans_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly frames walked front to back over a few columns, the rest noise
    task automatic random_traffic(input int n);
        int      sent;
        int      len;
        int      base;
        int      d;
        sample_t s;
        sent = 0;
        while (sent < n)
        begin
            s.column  = COLUMN_W'($urandom);
            s.depth   = DEPTH_W'($urandom);
            s.terrain = TERRAIN_W'($urandom);
            s.color   = COLOR_W'($urandom);
            s.step    = STEP_W'($urandom);
            if ($urandom_range(0, 99) < 80)
            begin
                s.kind = KIND_FRAME;
                send_sample(s);
                sent++;
                len  = $urandom_range(8, 40);
                base = ($urandom_range(0, 9) == 0) ? $urandom_range(1008, 1023)
                                                   : $urandom_range(0, 1008);
                d = $urandom_range(1, 256);
                repeat (len)
                begin
                    s.kind    = KIND_SAMPLE;
                    s.column  = (base + $urandom_range(0, 15) > 1023) ? COLUMN_W'(1023)
                                : COLUMN_W'(base + $urandom_range(0, 15));
                    s.depth   = DEPTH_W'(d);
                    s.terrain = TERRAIN_W'($urandom);
                    s.color   = COLOR_W'($urandom);
                    s.step    = ($urandom_range(0, 99) < 85)
                                ? STEP_W'($urandom_range(1, MAX_STEP))
                                : STEP_W'($urandom_range(0, 15));
                    send_sample(s);
                    sent++;
                    d = d + $urandom_range(1, d / 4 + 16);
                    if (d > 65535)
                        d = 65535;
                end
            end
            else
            begin
                s.kind = ($urandom_range(0, 9) == 0) ? KIND_FRAME : KIND_SAMPLE;
                send_sample(s);
                sent++;
            end
        end
    endtask

    initial
    begin
        sb = new();
        rst_n          = 1'b0;
        sample_valid   <= 1'b0;
        kind           <= KIND_FRAME;
        column         <= '0;
        depth          <= '0;
        terrain_height <= '0;
        texel_color    <= '0;
        step_width     <= '0;
        cfg_valid      <= 1'b0;
        cfg_index      <= CFG_CAMERA_HEIGHT;
        cfg_data       <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed samples at the reset settings
        send_fields(KIND_SAMPLE, 0, 0, 255, 0, 1);          // zero depth
        send_fields(KIND_SAMPLE, 0, 16, 0, 255, 1);         // row below the mark
        send_fields(KIND_SAMPLE, 1023, 65535, 0, 17, 8);    // clipped to one column
        send_fields(KIND_SAMPLE, 1020, 65535, 255, 200, 15); // oversized step, clipped
        send_fields(KIND_SAMPLE, 10, 1000, 100, 3, 0);      // step of zero
        send_fields(KIND_SAMPLE, 20, 300, 20, 255, 9);
        send_fields(KIND_SAMPLE, 40, 500, 20, 1, 8);        // row on the horizon
        send_fields(KIND_SAMPLE, 40, 900, 20, 2, 8);        // row equal to the mark
        send_fields(KIND_SAMPLE, 44, 65535, 200, 128, 4);
        send_fields(KIND_SAMPLE, 512, 1, 255, 85, 7);
        send_fields(KIND_SAMPLE, 513, 32768, 128, 170, 2);
        send_fields(KIND_FRAME, 1023, 65535, 255, 255, 15);
        send_fields(KIND_SAMPLE, 40, 500, 20, 4, 8);        // mark restored by frame start
        send_fields(KIND_SAMPLE, 1023, 1, 255, 0, 1);
        send_fields(KIND_SAMPLE, 341, 21845, 85, 85, 5);
        send_fields(KIND_SAMPLE, 682, 43690, 170, 170, 10);
        send_fields(KIND_FRAME, 0, 0, 0, 0, 0);
        send_fields(KIND_SAMPLE, 0, 65535, 255, 255, 8);
        settle();

        // Hold off the sink while spans keep coming back to back
        calm = 1'b1;
        send_fields(KIND_FRAME, 0, 0, 0, 0, 0);
        hold_req <= 1'b1;
        for (int i = 0; i < 100; i++)
            send_fields(KIND_SAMPLE, i * 8, $urandom, 255, $urandom, 8);
        calm = 1'b0;
        settle();

        write_regs(5120, 30720, 100, 200);
        random_traffic(PHASE_ITEMS);
        settle();
        write_regs(0, 1, 2047, 2047);
        random_traffic(PHASE_ITEMS);
        settle();
        write_regs(24'hFFFFFF, 16'hFFFF, -2048, 2047);
        random_traffic(PHASE_ITEMS);
        settle();
        write_regs(100 * 256, 200 * 256, -1024, 1);
        random_traffic(PHASE_ITEMS);
        settle();
        write_regs(40 * 256, 0, 0, 1024);
        random_traffic(PHASE_ITEMS);
        settle();
        calm = 1'b1;
        write_regs(30 * 256, 120 * 256, 240, 480);
        random_traffic(PHASE_ITEMS);
        settle();
        calm = 1'b0;
        repeat (3)
        begin
            write_regs($urandom_range(0, 300 * 256), $urandom_range(1, 65535),
                       $urandom_range(0, 4095), $urandom_range(1, 1024));
            random_traffic(PHASE_ITEMS);
            settle();
        end

        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[files.f]
src/vcos_pkg.sv
src/vcos_ram.sv
src/vcos_front.sv
src/vcos_div.sv
src/vcos_occl.sv
src/voxel_column_occlusion_spans_core.sv
dv/tb_voxel_column_occlusion_spans_core.sv
